/* src/bmf_pkg.sv */
// Package for the RGB box mean filter: item structs, register codes, reset values,
// state encoding and shared widths. No dependencies.
package bmf_pkg;

    localparam int SUM_W      = 16;
    localparam int COORD_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CHAN_MAX   = 255;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [3:0] size_t;
    typedef logic [8:0] dim_t;
    typedef logic [7:0] area_t;
    typedef logic [7:0] chan_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam cfg_idx_t CFG_WINDOW_SIZE  = 2'd0;
    localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd1;
    localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd2;

    localparam size_t WINDOW_SIZE_RST  = 4'd3;
    localparam dim_t  IMAGE_WIDTH_RST  = 9'd256;
    localparam dim_t  IMAGE_HEIGHT_RST = 9'd256;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef struct packed {
        logic  command;
        chan_t pos_x;
        chan_t pos_y;
        chan_t in_blue;
        chan_t in_green;
        chan_t in_red;
    } in_item_t;

    typedef struct packed {
        chan_t out_blue;
        chan_t out_green;
        chan_t out_red;
    } out_item_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

endpackage

/* src/bmf_frame_mem.sv */
// Frame store: single write port, single read port, registered read.
// Depends on bmf_pkg for the pixel type.
module bmf_frame_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  bmf_pkg::pixel_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output bmf_pkg::pixel_t rd_data
);

    bmf_pkg::pixel_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/bmf_div.sv */
// Three-lane restoring divider, one quotient bit per cycle, clamped byte results.
// Depends on bmf_pkg for sum and channel widths.
module bmf_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  bmf_pkg::area_t         divisor,
    input  bmf_pkg::sum_t  [2:0]   dividend,
    output bmf_pkg::chan_t [2:0]   quotient,
    output logic                   done
);

    localparam int STEP_W = $clog2(bmf_pkg::SUM_W);

    bmf_pkg::sum_t  [2:0] q_reg, q_next;
    bmf_pkg::area_t [2:0] rem_reg, rem_next;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_comb begin
        logic [8:0] rem_sh;
        logic       ge;
        rem_sh = '0;
        ge     = 1'b0;
        for (int l = 0; l < 3; l++) begin
            rem_sh      = {rem_reg[l], q_reg[l][bmf_pkg::SUM_W-1]};
            ge          = rem_sh >= {1'b0, divisor};
            rem_next[l] = ge ? 8'(rem_sh - {1'b0, divisor}) : rem_sh[7:0];
            q_next[l]   = {q_reg[l][bmf_pkg::SUM_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(bmf_pkg::SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            quotient[l] = (q_reg[l] > bmf_pkg::sum_t'(bmf_pkg::CHAN_MAX))
                        ? bmf_pkg::chan_t'(bmf_pkg::CHAN_MAX) : q_reg[l][7:0];
        end
    end

    assign done = done_reg;

endmodule

/* src/rgb_box_mean_filter.sv */
// Top level of the RGB box mean filter: config registers, window scan sequencer,
// accumulators and output register. Uses bmf_pkg, bmf_frame_mem and bmf_div.
//
//   channel | ports                       | transfer
//   --------+-----------------------------+-------------------------------
//   input   | s_valid s_ready s_data      | s_valid & s_ready
//   result  | m_valid m_ready m_data      | m_valid & m_ready
//   config  | cfg_wr_en cfg_index cfg_wdata | cfg_wr_en
//
// A write item stores the pixel in the frame store. A compute item walks the window
// positions in the scan state, reading the frame store for each position inside the
// image, then passes through the drain state, the divider start state, the wait for
// the bit-serial divider and the output state. Reset clears control registers and sets
// config registers to their reset values; the frame store holds junk until written.
// A stalled result holds the block in its output state; no input is taken meanwhile.
module rgb_box_mean_filter #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_WINDOW = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bmf_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bmf_pkg::out_item_t   m_data,
    input  logic                 cfg_wr_en,
    input  bmf_pkg::cfg_idx_t    cfg_index,
    input  bmf_pkg::cfg_data_t   cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bmf_pkg::size_t window_size_reg;
    bmf_pkg::dim_t  image_width_reg;
    bmf_pkg::dim_t  image_height_reg;

    bmf_pkg::state_t state_reg, state_next;

    bmf_pkg::coord_t x_base_reg, cur_x_reg, cur_y_reg;
    bmf_pkg::size_t  col_reg, row_reg, n_reg;
    bmf_pkg::area_t  nn_reg;
    logic            hit_reg;
    bmf_pkg::sum_t [2:0] sum_reg;

    logic               m_valid_reg;
    bmf_pkg::out_item_t m_data_reg;

    bmf_pkg::size_t  n_lim, n_cur, half;
    bmf_pkg::coord_t w_lim, h_lim;
    logic            in_img, last_col, last_pos;
    logic            s_xfer, compute_go, wr_en, rd_en, div_start, div_done, out_load;
    logic [AW-1:0]   wr_addr, rd_addr;
    bmf_pkg::pixel_t wr_data, rd_data;
    bmf_pkg::chan_t [2:0] quot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg  <= bmf_pkg::WINDOW_SIZE_RST;
            image_width_reg  <= bmf_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= bmf_pkg::IMAGE_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bmf_pkg::CFG_WINDOW_SIZE:  window_size_reg  <= cfg_wdata[3:0];
                bmf_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                bmf_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign n_lim = (int'(window_size_reg) > MAX_WINDOW) ? bmf_pkg::size_t'(MAX_WINDOW)
                                                        : window_size_reg;
    assign n_cur = {n_lim[3:1], 1'b1};
    assign half  = {1'b0, n_lim[3:1]};
    assign w_lim = (int'(image_width_reg) > MAX_WIDTH) ? bmf_pkg::coord_t'(MAX_WIDTH)
                                                       : bmf_pkg::coord_t'(image_width_reg);
    assign h_lim = (int'(image_height_reg) > MAX_HEIGHT) ? bmf_pkg::coord_t'(MAX_HEIGHT)
                                                         : bmf_pkg::coord_t'(image_height_reg);

    assign s_xfer     = s_valid && s_ready;
    assign compute_go = s_xfer && (s_data.command == bmf_pkg::CMD_COMPUTE);

    assign in_img   = (cur_x_reg >= 0) && (cur_x_reg < w_lim)
                   && (cur_y_reg >= 0) && (cur_y_reg < h_lim);
    assign last_col = (col_reg == n_reg - 1'b1);
    assign last_pos = last_col && (row_reg == n_reg - 1'b1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bmf_pkg::ST_IDLE: begin
                if (compute_go) begin
                    state_next = bmf_pkg::ST_SCAN;
                end
            end
            bmf_pkg::ST_SCAN: begin
                if (last_pos) begin
                    state_next = bmf_pkg::ST_DRAIN;
                end
            end
            bmf_pkg::ST_DRAIN:    state_next = bmf_pkg::ST_DIV_GO;
            bmf_pkg::ST_DIV_GO:   state_next = bmf_pkg::ST_DIV_WAIT;
            bmf_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = bmf_pkg::ST_OUT;
                end
            end
            bmf_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = bmf_pkg::ST_IDLE;
                end
            end
            default: state_next = bmf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            bmf_pkg::ST_IDLE:   s_ready   = 1'b1;
            bmf_pkg::ST_SCAN:   rd_en     = in_img;
            bmf_pkg::ST_DIV_GO: div_start = 1'b1;
            bmf_pkg::ST_OUT:    out_load  = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmf_pkg::ST_IDLE;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            hit_reg   <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (compute_go) begin
            x_base_reg <= bmf_pkg::coord_t'(s_data.pos_x) - bmf_pkg::coord_t'(half);
            cur_x_reg  <= bmf_pkg::coord_t'(s_data.pos_x) - bmf_pkg::coord_t'(half);
            cur_y_reg  <= bmf_pkg::coord_t'(s_data.pos_y) - bmf_pkg::coord_t'(half);
            col_reg    <= '0;
            row_reg    <= '0;
            n_reg      <= n_cur;
            nn_reg     <= 8'({4'd0, n_cur} * {4'd0, n_cur});
        end else if (state_reg == bmf_pkg::ST_SCAN) begin
            if (last_col) begin
                col_reg   <= '0;
                row_reg   <= row_reg + 1'b1;
                cur_x_reg <= x_base_reg;
                cur_y_reg <= cur_y_reg + 1'b1;
            end else begin
                col_reg   <= col_reg + 1'b1;
                cur_x_reg <= cur_x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (compute_go) begin
            sum_reg <= '0;
        end else if (hit_reg) begin
            sum_reg[0] <= sum_reg[0] + bmf_pkg::sum_t'(rd_data.blue);
            sum_reg[1] <= sum_reg[1] + bmf_pkg::sum_t'(rd_data.green);
            sum_reg[2] <= sum_reg[2] + bmf_pkg::sum_t'(rd_data.red);
        end
    end

    assign wr_en   = s_xfer && (s_data.command == bmf_pkg::CMD_WRITE)
                  && (int'(s_data.pos_x) < MAX_WIDTH) && (int'(s_data.pos_y) < MAX_HEIGHT);
    assign wr_addr = AW'(int'(s_data.pos_y) * MAX_WIDTH + int'(s_data.pos_x));
    assign wr_data = '{red: s_data.in_red, green: s_data.in_green, blue: s_data.in_blue};
    assign rd_addr = AW'(int'(cur_y_reg[bmf_pkg::COORD_W-2:0]) * MAX_WIDTH
                       + int'(cur_x_reg[bmf_pkg::COORD_W-2:0]));

    bmf_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bmf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (nn_reg),
        .dividend (sum_reg),
        .quotient (quot),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= '{out_blue: quot[0], out_green: quot[1], out_red: quot[2]};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* src/bmf_checker.sv */
// Port-level checks for the RGB box mean filter, bound to the top level.
// Depends on bmf_pkg for item types and command codes.
module bmf_assertions (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input bmf_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input bmf_pkg::out_item_t m_data
);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result dropped or changed");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.command == bmf_pkg::CMD_WRITE) && !m_valid
        |=> !m_valid)
        else $error("write transfer produced a result");

    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.command == bmf_pkg::CMD_COMPUTE) |=> !s_ready)
        else $error("input taken while a window is in progress");

endmodule

bind rgb_box_mean_filter bmf_assertions u_bmf_assertions (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
